>>> rtl/lsg_pkg.sv
// Shared constants and codes for the line span generator.
`timescale 1ns / 1ps

package lsg_pkg;

  // Default coordinate width of the endpoints and the run origin.
  localparam int unsigned COORD_BITS_DEF = 16;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Command codes carried in the input tuser.
  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  // Queue occupancy seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> rtl/lsg_queue.sv
// Small register queue that carries classified commands from front to back.
`timescale 1ns / 1ps

module lsg_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = lsg_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output lsg_pkg::queue_status_t status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == (AW+1)'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/lsg_front.sv
// Front end: accepts commands and works out the line set-up for loads.
`timescale 1ns / 1ps

module lsg_front #(
  parameter int unsigned COORD_BITS = lsg_pkg::COORD_BITS_DEF,
  parameter int unsigned QW         = 4 * COORD_BITS + 7
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic                           cmd,
  input  logic signed [COORD_BITS-1:0]   start_x,
  input  logic signed [COORD_BITS-1:0]   start_y,
  input  logic signed [COORD_BITS-1:0]   end_x,
  input  logic signed [COORD_BITS-1:0]   end_y,
  input  logic                           include_end,
  input  lsg_pkg::queue_status_t         q_status,
  output logic                           q_push,
  output logic [QW-1:0]                  q_data
);

  localparam int unsigned CB = COORD_BITS;

  logic signed [CB:0] dx;
  logic signed [CB:0] dy;
  logic [CB:0]        adx_full;
  logic [CB:0]        ady_full;
  logic [CB-1:0]      adx;
  logic [CB-1:0]      ady;
  logic               y_major;
  logic [1:0]         sx;
  logic [1:0]         sy;
  logic [CB-1:0]      major;
  logic [CB-1:0]      minor;
  logic               is_load;

  assign dx = {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
  assign dy = {end_y[CB-1], end_y} - {start_y[CB-1], start_y};

  assign adx_full = dx[CB] ? (CB+1)'(-dx) : dx;
  assign ady_full = dy[CB] ? (CB+1)'(-dy) : dy;
  assign adx      = adx_full[CB-1:0];
  assign ady      = ady_full[CB-1:0];

  assign sx = dx[CB] ? 2'b11 : ((dx != '0) ? 2'b01 : 2'b00);
  assign sy = dy[CB] ? 2'b11 : ((dy != '0) ? 2'b01 : 2'b00);

  assign y_major = (adx < ady);
  assign major   = y_major ? ady : adx;
  assign minor   = y_major ? adx : ady;
  assign is_load = (cmd == lsg_pkg::CMD_LOAD);

  assign s_tready = !q_status.full;
  assign q_push   = s_tvalid && s_tready;

  // Entry from the lowest bit up: load flag, x1, y1, major, minor, sx, sy,
  // y_major, include_end.
  assign q_data = {include_end, y_major, sy, sx, minor, major, start_y, start_x, is_load};

endmodule

>>> rtl/lsg_back.sv
// Back end: walks the line a major step a cycle until a run ends; forms runs.
`timescale 1ns / 1ps

module lsg_back #(
  parameter int unsigned COORD_BITS = lsg_pkg::COORD_BITS_DEF,
  parameter int unsigned QW         = 4 * COORD_BITS + 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lsg_pkg::queue_status_t        q_status,
  input  logic [QW-1:0]                 q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_has,
  output logic signed [COORD_BITS-1:0]  out_x,
  output logic signed [COORD_BITS-1:0]  out_y,
  output logic [COORD_BITS:0]           out_len,
  output logic                          out_vert,
  output logic                          out_done
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned PW = CB + 1;
  localparam int unsigned EW = CB + 2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state;

  // Queue entry fields
  logic          e_load;
  logic [CB-1:0] e_x1;
  logic [CB-1:0] e_y1;
  logic [CB-1:0] e_major;
  logic [CB-1:0] e_minor;
  logic [1:0]    e_sx;
  logic [1:0]    e_sy;
  logic          e_ymaj;
  logic          e_inc;

  assign {e_inc, e_ymaj, e_sy, e_sx, e_minor, e_major, e_y1, e_x1, e_load} = q_data;

  // Line state
  logic          active;
  logic [PW-1:0] pos_x;
  logic [PW-1:0] pos_y;
  logic [PW-1:0] org_x;
  logic [PW-1:0] org_y;
  logic [1:0]    stp_x;
  logic [1:0]    stp_y;
  logic [CB-1:0] major;
  logic [CB-1:0] minor;
  logic [EW-1:0] err;
  logic [CB:0]   steps;
  logic          y_major;

  logic          out_free;
  logic          out_set;
  logic          minor_moved;
  logic [EW-1:0] len;
  logic          len_neg;
  logic [EW-1:0] len_mag;
  logic [PW-1:0] run_ox;
  logic [PW-1:0] run_oy;
  logic          run_has;
  logic [EW-1:0] err_sub;
  logic [EW-1:0] err_add;
  logic          minor_step;
  logic [PW-1:0] pos_x_step;
  logic [PW-1:0] pos_y_step;

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == ST_IDLE) && !q_status.empty && (e_load || out_free);

  assign minor_moved = y_major ? (pos_x != org_x) : (pos_y != org_y);

  // Load a new result into the output register this cycle.
  assign out_set = ((state == ST_IDLE) && q_pop && !e_load && !active)
                || ((state == ST_WALK) && (minor_moved || steps == '0) && !out_valid);

  assign len = y_major ? ({pos_y[PW-1], pos_y} - {org_y[PW-1], org_y})
                       : ({pos_x[PW-1], pos_x} - {org_x[PW-1], org_x});
  assign len_neg = len[EW-1];
  assign len_mag = len_neg ? EW'(-len) : len;
  assign run_has = (len != '0);

  // A backward walk reports its run from the pixel after the current one.
  assign run_ox = (!y_major && len_neg) ? pos_x + PW'(1) : org_x;
  assign run_oy = (y_major && len_neg) ? pos_y + PW'(1) : org_y;

  assign err_sub    = err - {2'b00, minor};
  assign err_add    = err_sub + {2'b00, major};
  assign minor_step = err_sub[EW-1];
  assign pos_x_step = pos_x + {{(PW-2){stp_x[1]}}, stp_x};
  assign pos_y_step = pos_y + {{(PW-2){stp_y[1]}}, stp_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= 1'b0;
      out_valid <= 1'b0;
      pos_x     <= '0;
      pos_y     <= '0;
      org_x     <= '0;
      org_y     <= '0;
      stp_x     <= '0;
      stp_y     <= '0;
      major     <= '0;
      minor     <= '0;
      err       <= '0;
      steps     <= '0;
      y_major   <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (e_load) begin
              pos_x   <= {e_x1[CB-1], e_x1};
              pos_y   <= {e_y1[CB-1], e_y1};
              org_x   <= {e_x1[CB-1], e_x1};
              org_y   <= {e_y1[CB-1], e_y1};
              stp_x   <= e_sx;
              stp_y   <= e_sy;
              major   <= e_major;
              minor   <= e_minor;
              y_major <= e_ymaj;
              err     <= EW'(e_major >> 1);
              steps   <= {1'b0, e_major} + {{CB{1'b0}}, e_inc};
              active  <= 1'b1;
            end else if (!active) begin
              // Advance with no line: answer done, no run.
              out_has   <= 1'b0;
              out_x     <= '0;
              out_y     <= '0;
              out_len   <= '0;
              out_vert  <= 1'b0;
              out_done  <= 1'b1;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (minor_moved || steps == '0) begin
            if (!out_valid) begin
              out_has   <= run_has;
              out_x     <= run_has ? run_ox[CB-1:0] : '0;
              out_y     <= run_has ? run_oy[CB-1:0] : '0;
              out_len   <= run_has ? len_mag[CB:0] : '0;
              out_vert  <= run_has && y_major;
              out_done  <= !minor_moved;
              if (minor_moved) begin
                org_x <= pos_x;
                org_y <= pos_y;
              end else begin
                active <= 1'b0;
              end
              state <= ST_IDLE;
            end
          end else begin
            // Advance one pixel along the major axis.
            steps <= steps - (CB+1)'(1);
            err   <= minor_step ? err_add : err_sub;
            if (y_major) begin
              pos_y <= pos_y_step;
              if (minor_step) begin
                pos_x <= pos_x_step;
              end
            end else begin
              pos_x <= pos_x_step;
              if (minor_step) begin
                pos_y <= pos_y_step;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/line_span_generator.sv
// Top level of the line span generator: front end, command queue and walker.
`timescale 1ns / 1ps

// A load command is taken into the walker's line state as it leaves the
// queue and gives no result. An advance leaves the queue, then the walker
// steps once for each major-axis pixel of the run and then forms the
// result. The two-entry command queue lets new commands be taken while
// the walker is busy or a result waits on the output.
module line_span_generator #(
  parameter int unsigned COORD_BITS = lsg_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // start_x, start_y, end_x, end_y, include_end, zero pad
  input  logic [((4*COORD_BITS+1+7)/8)*8-1:0]      s_tdata,
  // cmd
  input  logic [0:0]                               s_tuser,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // run_x, run_y, run_length, vertical, zero pad
  output logic [((3*COORD_BITS+2+7)/8)*8-1:0]      m_tdata,
  // has_run
  output logic [0:0]                               m_tuser,
  // line_done
  output logic                                     m_tlast
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned QW = 4 * CB + 7;
  localparam int unsigned OW = ((3 * CB + 2 + 7) / 8) * 8;

  lsg_pkg::queue_status_t q_status;
  logic                   q_push;
  logic                   q_pop;
  logic [QW-1:0]          q_in;
  logic [QW-1:0]          q_out;

  logic                   out_has;
  logic signed [CB-1:0]   out_x;
  logic signed [CB-1:0]   out_y;
  logic [CB:0]            out_len;
  logic                   out_vert;
  logic                   out_done;

  lsg_front #(
    .COORD_BITS (CB),
    .QW         (QW)
  ) u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .cmd         (s_tuser[0]),
    .start_x     (s_tdata[CB-1:0]),
    .start_y     (s_tdata[2*CB-1:CB]),
    .end_x       (s_tdata[3*CB-1:2*CB]),
    .end_y       (s_tdata[4*CB-1:3*CB]),
    .include_end (s_tdata[4*CB]),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  lsg_queue #(
    .WIDTH (QW),
    .DEPTH (lsg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .status    (q_status)
  );

  lsg_back #(
    .COORD_BITS (CB),
    .QW         (QW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_has   (out_has),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_len   (out_len),
    .out_vert  (out_vert),
    .out_done  (out_done)
  );

  assign m_tdata = OW'({out_vert, out_len, out_y, out_x});
  assign m_tuser = out_has;
  assign m_tlast = out_done;

endmodule

>>> rtl/lsg_checker.sv
// Port-level checks for the line span generator, bound to the top level.
`timescale 1ns / 1ps

module lsg_checker #(
  parameter int unsigned COORD_BITS = lsg_pkg::COORD_BITS_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [((3*COORD_BITS+2+7)/8)*8-1:0]   m_tdata,
  input logic [0:0]                            m_tuser,
  input logic                                  m_tlast
);

  localparam int unsigned CB = COORD_BITS;

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // A result without a run carries all-zero run fields.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("empty result with nonzero fields");

  // A result with a run has a nonzero length.
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[3*CB:2*CB] != '0)
    else $error("run of zero length");

  // An empty result always ends the line.
  a_empty_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("empty result without line end");

  // Nothing comes out straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result presented after reset");

endmodule

bind line_span_generator lsg_checker #(.COORD_BITS(COORD_BITS)) u_lsg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> test/tb.sv
// Self-checking bench for the line span generator: runs of random and edge-case lines.
`timescale 1ns / 1ps

module tb;

  localparam int CB = 16;
  localparam int SD_W = ((4*CB+1+7)/8)*8;
  localparam int MD_W = ((3*CB+2+7)/8)*8;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic        has_run;
    logic [15:0] run_x;
    logic [15:0] run_y;
    logic [16:0] run_length;
    logic        vertical;
    logic        line_done;
  } span_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SD_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MD_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic m_tlast;

  line_span_generator i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Walker state mirrored; positions carry one spare bit, as in the block.
  logic               ln_active = 1'b0;
  logic signed [16:0] cur_x = '0, cur_y = '0, org_x = '0, org_y = '0;
  logic signed [1:0]  dir_x = '0, dir_y = '0;
  logic signed [16:0] d_major = '0, d_minor = '0;
  logic signed [17:0] err = '0, steps_rem = '0;
  logic               steep = 1'b0;

  span_t runs_due[$];
  int    fails = 0;
  int    items_sent = 0;
  int    cycles = 0;
  bit    src_idle_on = 1'b1;
  bit    sink_idle_on = 1'b1;

  // Report the pending run from the origin to the current major position.
  function automatic span_t close_run(bit done);
    span_t s;
    logic signed [17:0] len;
    logic signed [16:0] ox, oy;
    ox = org_x;
    oy = org_y;
    len = steep ? cur_y - oy : cur_x - ox;
    s = '0;
    s.line_done = done;
    if (len != 0) begin
      if (len < 0) begin
        if (steep) oy = cur_y + 17'sd1;
        else ox = cur_x + 17'sd1;
        len = -len;
      end
      s.has_run = 1'b1;
      s.run_x = ox[15:0];
      s.run_y = oy[15:0];
      s.run_length = len[16:0];
      s.vertical = steep;
    end
    return s;
  endfunction

  // Apply one command to the mirrored walker; returns 1 when it yields a result.
  function automatic bit walk_command(input lsg_pkg::cmd_t c, input logic [SD_W-1:0] d,
                                      output span_t r);
    logic signed [15:0] x1, y1, x2, y2;
    logic signed [16:0] dx, dy, adx, ady;
    r = '0;
    if (c == lsg_pkg::CMD_LOAD) begin
      x1 = d[15:0];
      y1 = d[31:16];
      x2 = d[47:32];
      y2 = d[63:48];
      dx = x2 - x1;
      dy = y2 - y1;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      dir_x = (dx > 0) ? 2'sb01 : (dx < 0) ? 2'sb11 : 2'sb00;
      dir_y = (dy > 0) ? 2'sb01 : (dy < 0) ? 2'sb11 : 2'sb00;
      cur_x = x1;
      org_x = x1;
      cur_y = y1;
      org_y = y1;
      steep = adx < ady;
      d_major = steep ? ady : adx;
      d_minor = steep ? adx : ady;
      err = d_major >>> 1;
      steps_rem = d_major;
      if (d[64]) steps_rem = steps_rem + 18'sd1;
      ln_active = 1'b1;
      return 1'b0;
    end
    if (!ln_active) begin
      r.line_done = 1'b1;
      return 1'b1;
    end
    while (1) begin
      if (steep ? (cur_x != org_x) : (cur_y != org_y)) begin
        r = close_run(1'b0);
        org_x = cur_x;
        org_y = cur_y;
        return 1'b1;
      end
      if (steps_rem <= 0) begin
        ln_active = 1'b0;
        r = close_run(1'b1);
        return 1'b1;
      end
      steps_rem = steps_rem - 18'sd1;
      err = err - d_minor;
      if (steep) begin
        cur_y = cur_y + dir_y;
        if (err < 0) begin
          err = err + d_major;
          cur_x = cur_x + dir_x;
        end
      end else begin
        cur_x = cur_x + dir_x;
        if (err < 0) begin
          err = err + d_major;
          cur_y = cur_y + dir_y;
        end
      end
    end
  endfunction

  function automatic logic [SD_W-1:0] pack_cmd(logic [15:0] x1, logic [15:0] y1,
                                               logic [15:0] x2, logic [15:0] y2, logic inc);
    return {7'b0, inc, y2, x2, y1, x1};
  endfunction

  task automatic send_item(lsg_pkg::cmd_t c, logic [SD_W-1:0] d);
    span_t r;
    while (src_idle_on && $urandom_range(99) < 34) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= c;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (walk_command(c, d, r)) runs_due.push_back(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_advance();
    send_item(lsg_pkg::CMD_ADVANCE,
              pack_cmd(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom)));
  endtask

  // Load a line, then advance until it is done or the cap is reached.
  task automatic trace_line(logic [15:0] x1, logic [15:0] y1, logic [15:0] x2,
                            logic [15:0] y2, logic inc, int max_adv);
    send_item(lsg_pkg::CMD_LOAD, pack_cmd(x1, y1, x2, y2, inc));
    for (int k = 0; k < max_adv && ln_active; k++) send_advance();
  endtask

  task automatic pick_line(output logic [15:0] x1, output logic [15:0] y1,
                           output logic [15:0] x2, output logic [15:0] y2);
    int bx, by, ex, ey, dx, dy, reach;
    reach = ($urandom_range(99) < 5) ? 3000 : 40;
    bx = int'($urandom_range(65535)) - 32768;
    by = int'($urandom_range(65535)) - 32768;
    dx = int'($urandom_range(2*reach)) - reach;
    dy = int'($urandom_range(2*reach)) - reach;
    case ($urandom_range(19))
      0: dy = 0;
      1: dx = 0;
      2: dy = dx;
      3: dy = -dx;
      4: begin
        dx = 0;
        dy = 0;
      end
      default: ;
    endcase
    ex = bx + dx;
    if (ex > 32767 || ex < -32768) ex = bx - dx;
    ey = by + dy;
    if (ey > 32767 || ey < -32768) ey = by - dy;
    x1 = bx[15:0];
    y1 = by[15:0];
    x2 = ex[15:0];
    y2 = ey[15:0];
  endtask

  task automatic test_directed();
    send_advance();
    trace_line(16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b1, 2);
    trace_line(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 1'b1, 2);
    trace_line(16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 1'b0, 1);
    trace_line(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b1, 3);
    trace_line(16'sd0, 16'sd0, 16'sd3, 16'sd1, 1'b0, 6);
    trace_line(16'sd0, 16'sd0, -16'sd1, -16'sd3, 1'b1, 6);
    trace_line(16'sd10, -16'sd4, 16'sd3, 16'sd2, 1'b0, 6);
  endtask

  // Hold the sender mid-line until every outstanding run has come back.
  task automatic test_pause_mid_line();
    trace_line(16'sd0, 16'sd0, 16'sd20, 16'sd7, 1'b1, 2);
    wait_drained();
    while (ln_active) send_advance();
  endtask

  task automatic test_random(int n_items);
    logic [15:0] x1, y1, x2, y2;
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        pick_line(x1, y1, x2, y2);
        trace_line(x1, y1, x2, y2, 1'($urandom_range(1)),
                   ($urandom_range(9) == 0) ? $urandom_range(3) : 64);
        if ($urandom_range(9) == 0) send_advance();
      end else begin
        send_item(lsg_pkg::cmd_t'($urandom_range(1)),
                  pack_cmd(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           1'($urandom)));
      end
    end
  endtask

  task automatic test_back_to_back(int n_items);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random(n_items);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    m_tready <= sink_idle_on ? ($urandom_range(99) >= 34) : 1'b1;
  end

  always @(posedge clk) begin : check_runs
    span_t want;
    span_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '0;
      got.has_run = m_tuser[0];
      got.run_x = m_tdata[15:0];
      got.run_y = m_tdata[31:16];
      got.run_length = m_tdata[48:32];
      got.vertical = m_tdata[49];
      got.line_done = m_tlast;
      if (runs_due.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fails++;
      end else begin
        want = runs_due.pop_front();
        if (got.has_run !== want.has_run) begin
          $error("has_run: expected %0d, got %0d", want.has_run, got.has_run);
          fails++;
        end
        if (got.run_x !== want.run_x) begin
          $error("run_x: expected %0d, got %0d", $signed(want.run_x), $signed(got.run_x));
          fails++;
        end
        if (got.run_y !== want.run_y) begin
          $error("run_y: expected %0d, got %0d", $signed(want.run_y), $signed(got.run_y));
          fails++;
        end
        if (got.run_length !== want.run_length) begin
          $error("run_length: expected %0d, got %0d", want.run_length, got.run_length);
          fails++;
        end
        if (got.vertical !== want.vertical) begin
          $error("vertical: expected %0d, got %0d", want.vertical, got.vertical);
          fails++;
        end
        if (got.line_done !== want.line_done) begin
          $error("line_done: expected %0d, got %0d", want.line_done, got.line_done);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_pause_mid_line();
    test_random(1450);
    test_back_to_back(350);
    wait_drained();
    repeat (64) @(posedge clk);
    if (fails == 0 && runs_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lsg_pkg.sv
rtl/lsg_queue.sv
rtl/lsg_front.sv
rtl/lsg_back.sv
rtl/line_span_generator.sv
rtl/lsg_checker.sv
test/tb.sv
